>>> rtl/lrf_pkg.sv
// Local range filter package: sizes, register map, queue word layout and
// shared helpers for gray conversion and output position. No dependencies.
`timescale 1ns / 1ps

package lrf_pkg;

  localparam int MAX_RADIUS_DEF = 3;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int CFG_RAD_MAX    = 3;

  localparam int RAD_W     = 2;
  localparam int WID_W     = 11;
  localparam int HGT_W     = 13;
  localparam int ROW_W     = 14;
  localparam int POS_W     = 15;
  localparam int COL_MAX_W = 12;
  localparam int SLOT_W    = 3;
  localparam int PIX_W     = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [RAD_W-1:0] RADIUS_RST = 2'd1;
  localparam logic [WID_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic [PIX_W-1:0]     gray;
    logic                 wr;
    logic                 emit;
    logic                 interior;
    logic                 last;
    logic [COL_MAX_W-1:0] col;
    logic [SLOT_W-1:0]    slot;
    logic [SLOT_W-1:0]    cslot;
  } lrf_item_t;

  typedef struct packed {
    logic             ok;
    logic [POS_W-1:0] qx;
    logic [POS_W-1:0] qy;
  } lrf_qpos_t;

  function automatic logic [PIX_W-1:0] lrf_gray(input logic [PIX_W-1:0] red,
                                                input logic [PIX_W-1:0] green,
                                                input logic [PIX_W-1:0] blue);
    logic [22:0] acc;
    acc = 23'd4899 * 23'(red) + 23'd9617 * 23'(green) + 23'd1868 * 23'(blue) + 23'd8192;
    return acc[21:14];
  endfunction

  // step the position back by radius pixels and radius rows
  function automatic lrf_qpos_t lrf_qpos(input logic [ROW_W-1:0] row,
                                         input logic [COL_MAX_W-1:0] col,
                                         input logic [RAD_W-1:0] rad,
                                         input logic [WID_W-1:0] wid);
    logic [POS_W-1:0] qx;
    logic [POS_W-1:0] qy;
    lrf_qpos_t res;
    qx = POS_W'(col);
    qy = POS_W'(row);
    for (int k = 0; k < CFG_RAD_MAX; k++) begin
      if (k < int'(rad)) begin
        if (qx == '0) begin
          qx = POS_W'(wid) - 1'b1;
          qy = qy - 1'b1;
        end else begin
          qx = qx - 1'b1;
        end
      end
    end
    qy = qy - POS_W'(rad);
    res.ok = !qy[POS_W-1];
    res.qx = qx;
    res.qy = qy;
    return res;
  endfunction

endpackage

>>> rtl/lrf_if.sv
// Stream interfaces for pixel words in and result words out.
// Depends on lrf_pkg.
`timescale 1ns / 1ps

interface lrf_in_if;
  logic                      valid;
  logic                      ready;
  logic [lrf_pkg::PIX_W-1:0] red;
  logic [lrf_pkg::PIX_W-1:0] green;
  logic [lrf_pkg::PIX_W-1:0] blue;
  logic                      flush;
  modport source (output valid, red, green, blue, flush, input ready);
  modport sink (input valid, red, green, blue, flush, output ready);
endinterface

interface lrf_out_if;
  logic                      valid;
  logic                      ready;
  logic [lrf_pkg::PIX_W-1:0] value;
  logic                      is_interior;
  logic                      last;
  modport source (output valid, value, is_interior, last, input ready);
  modport sink (input valid, value, is_interior, last, output ready);
endinterface

>>> rtl/local_range_filter_core.sv
// Local range filter top: APB registers, front end, queue and back end.
// Depends on lrf_pkg, lrf_if, lrf_front, lrf_fifo, lrf_back, lrf_ram.
// Throughput: one word per cycle while the output is not held by back-pressure;
// the line store rows are separate RAMs with one write and one read each cycle.
// The word that releases a result passes the queue, stages s1, s2 and s3 and the output register.
// Reset: position, queue and pipeline clear; radius 1, width 640, height 480.
// The line store is not cleared.
`timescale 1ns / 1ps

module local_range_filter_core #(
  parameter int MAX_RADIUS = lrf_pkg::MAX_RADIUS_DEF,
  parameter int MAX_WIDTH  = lrf_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lrf_in_if.sink                      in_px,
  lrf_out_if.source                   out_px,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrf_pkg::APB_AW-1:0]  paddr,
  input  logic [lrf_pkg::APB_DW-1:0]  pwdata,
  output logic [lrf_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int USE_RAD = (MAX_RADIUS < lrf_pkg::CFG_RAD_MAX) ? MAX_RADIUS
                                                               : lrf_pkg::CFG_RAD_MAX;
  localparam int SLOTS   = 2 * USE_RAD + 1;

  logic [lrf_pkg::RAD_W-1:0] radius_r;
  logic [lrf_pkg::WID_W-1:0] width_r;
  logic [lrf_pkg::HGT_W-1:0] height_r;
  logic [lrf_pkg::RAD_W-1:0] rad_eff;
  logic [lrf_pkg::WID_W-1:0] wid_eff;
  logic [lrf_pkg::HGT_W-1:0] hgt_eff;
  logic                      wr_en;
  logic [1:0]                reg_idx;
  logic                      q_push, q_pop, q_empty, q_full;
  lrf_pkg::lrf_item_t        fr_item, q_head;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= lrf_pkg::RADIUS_RST;
      width_r  <= lrf_pkg::WIDTH_RST;
      height_r <= lrf_pkg::HEIGHT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        lrf_pkg::REG_RADIUS: radius_r <= pwdata[lrf_pkg::RAD_W-1:0];
        lrf_pkg::REG_WIDTH:  width_r  <= pwdata[lrf_pkg::WID_W-1:0];
        lrf_pkg::REG_HEIGHT: height_r <= pwdata[lrf_pkg::HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lrf_pkg::REG_RADIUS: prdata = lrf_pkg::APB_DW'(radius_r);
      lrf_pkg::REG_WIDTH:  prdata = lrf_pkg::APB_DW'(width_r);
      lrf_pkg::REG_HEIGHT: prdata = lrf_pkg::APB_DW'(height_r);
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    rad_eff = (int'(radius_r) > MAX_RADIUS) ? lrf_pkg::RAD_W'(MAX_RADIUS) : radius_r;
    if (width_r == '0) wid_eff = lrf_pkg::WID_W'(1);
    else if (int'(width_r) > MAX_WIDTH) wid_eff = lrf_pkg::WID_W'(MAX_WIDTH);
    else wid_eff = width_r;
    hgt_eff = (height_r == '0) ? lrf_pkg::HGT_W'(1) : height_r;
  end

  assign in_px.ready = !q_full;
  assign q_push      = in_px.valid && !q_full;

  lrf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (q_push),
    .red    (in_px.red),
    .green  (in_px.green),
    .blue   (in_px.blue),
    .rad    (rad_eff),
    .wid    (wid_eff),
    .hgt    (hgt_eff),
    .item   (fr_item)
  );

  lrf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (fr_item),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  lrf_back #(.MAX_WIDTH(MAX_WIDTH), .SLOTS(SLOTS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_empty),
    .pop     (q_pop),
    .rad     (rad_eff),
    .out_px  (out_px)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (q_full && !q_pop) |=> q_full)
    else $error("queue left full state without a read");

endmodule

>>> rtl/lrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/lrf_front.sv
// Front end: tracks the stream position, converts to gray and classifies
// each word (store write, result, interior, last). Depends on lrf_pkg.
`timescale 1ns / 1ps

module lrf_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [lrf_pkg::PIX_W-1:0]         red,
  input  logic [lrf_pkg::PIX_W-1:0]         green,
  input  logic [lrf_pkg::PIX_W-1:0]         blue,
  input  logic [lrf_pkg::RAD_W-1:0]         rad,
  input  logic [lrf_pkg::WID_W-1:0]         wid,
  input  logic [lrf_pkg::HGT_W-1:0]         hgt,
  output lrf_pkg::lrf_item_t                item
);

  localparam int POS_W  = lrf_pkg::POS_W;
  localparam int SLOT_W = lrf_pkg::SLOT_W;

  logic [lrf_pkg::ROW_W-1:0]     row_r, row_nxt, row_cur;
  logic [lrf_pkg::COL_MAX_W-1:0] col_r, col_nxt, col_cur;
  logic [SLOT_W-1:0]             slot_r, slot_nxt, slot_cur;
  lrf_pkg::lrf_qpos_t            q_raw, q_zero, q;
  logic                          restart;
  logic [POS_W-1:0]              r_ext, w_ext, h_ext, col_inc;
  logic [SLOT_W-1:0]             two_r, r_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (accept) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_comb begin
    r_ext   = POS_W'(rad);
    w_ext   = POS_W'(wid);
    h_ext   = POS_W'(hgt);
    two_r   = SLOT_W'({rad, 1'b0});
    r_s     = SLOT_W'(rad);
    q_raw   = lrf_pkg::lrf_qpos(row_r, col_r, rad, wid);
    q_zero  = lrf_pkg::lrf_qpos('0, '0, rad, wid);
    restart = (POS_W'(col_r) >= w_ext) || (q_raw.ok && q_raw.qy >= h_ext);
    q        = restart ? q_zero : q_raw;
    row_cur  = restart ? '0 : row_r;
    col_cur  = restart ? '0 : col_r;
    slot_cur = restart ? '0 : slot_r;

    item.gray     = lrf_pkg::lrf_gray(red, green, blue);
    item.wr       = POS_W'(row_cur) < h_ext;
    item.emit     = q.ok;
    item.interior = q.ok && (q.qy >= r_ext) && (q.qy + r_ext < h_ext) &&
                    (q.qx >= r_ext) && (q.qx + r_ext < w_ext);
    item.last     = q.ok && (q.qy == h_ext - 1'b1) && (q.qx == w_ext - 1'b1);
    item.col      = col_cur;
    item.slot     = slot_cur;
    item.cslot    = (slot_cur >= r_s) ? slot_cur - r_s : slot_cur + r_s + 1'b1;

    col_inc  = POS_W'(col_cur) + 1'b1;
    row_nxt  = row_cur;
    col_nxt  = col_cur + 1'b1;
    slot_nxt = slot_cur;
    if (item.emit && item.last) begin
      row_nxt  = '0;
      col_nxt  = '0;
      slot_nxt = '0;
    end else if (col_inc == w_ext) begin
      row_nxt  = row_cur + 1'b1;
      col_nxt  = '0;
      slot_nxt = (slot_cur == two_r) ? '0 : slot_cur + 1'b1;
    end
  end

endmodule

>>> rtl/lrf_fifo.sv
// Short queue of classified words between front and back end.
// Depends on lrf_pkg.
`timescale 1ns / 1ps

module lrf_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lrf_pkg::lrf_item_t push_item,
  input  logic               pop,
  output lrf_pkg::lrf_item_t head,
  output logic               empty,
  output logic               full
);

  localparam int DEPTH = lrf_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lrf_pkg::lrf_item_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wp_r, rp_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop) rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  assign head  = mem_r[rp_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_W'(DEPTH));

endmodule

>>> rtl/lrf_back.sv
// Back end: line store access, column min/max, horizontal window and the
// result register. Depends on lrf_pkg, lrf_if and lrf_ram.
`timescale 1ns / 1ps

module lrf_back #(
  parameter int MAX_WIDTH = lrf_pkg::MAX_WIDTH_DEF,
  parameter int SLOTS     = 2 * lrf_pkg::MAX_RADIUS_DEF + 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lrf_pkg::lrf_item_t        head,
  input  logic                      q_empty,
  output logic                      pop,
  input  logic [lrf_pkg::RAD_W-1:0] rad,
  lrf_out_if.source                 out_px
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int PIX_W  = lrf_pkg::PIX_W;
  localparam int SLOT_W = lrf_pkg::SLOT_W;

  logic               adv;
  logic               s1_v_r, s2_v_r, s3_v_r;
  lrf_pkg::lrf_item_t s1_r, s2_r, s3_r;
  logic [PIX_W-1:0]   rdat [SLOTS];
  logic [PIX_W-1:0]   cmn_r [SLOTS];
  logic [PIX_W-1:0]   cmx_r [SLOTS];
  logic [PIX_W-1:0]   cct_r [SLOTS];
  logic [PIX_W-1:0]   c_mn, c_mx, c_ct, v;
  logic [PIX_W-1:0]   w_mn, w_mx, w_ct;
  logic [SLOT_W-1:0]  two_r;
  logic               out_v_r;
  logic [PIX_W-1:0]   out_val_r;
  logic               out_int_r, out_last_r;

  assign adv   = !out_v_r || out_px.ready;
  assign pop   = adv && !q_empty;
  assign two_r = SLOT_W'({rad, 1'b0});

  for (genvar s = 0; s < SLOTS; s++) begin : g_row
    lrf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
      .clk     (clk),
      .we      (adv && s1_v_r && s1_r.wr && (s1_r.slot == SLOT_W'(s))),
      .wr_addr (s1_r.col[ADDR_W-1:0]),
      .wr_data (s1_r.gray),
      .rd_en   (adv),
      .rd_addr (s1_r.col[ADDR_W-1:0]),
      .rd_data (rdat[s])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= pop;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      out_v_r <= s3_v_r && s3_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r       <= head;
      s2_r       <= s1_r;
      s3_r       <= s2_r;
      out_val_r  <= s3_r.interior ? w_mx - w_mn : w_ct;
      out_int_r  <= s3_r.interior;
      out_last_r <= s3_r.last;
      if (s2_v_r) begin
        cmn_r[0] <= c_mn;
        cmx_r[0] <= c_mx;
        cct_r[0] <= c_ct;
        for (int k = 1; k < SLOTS; k++) begin
          cmn_r[k] <= cmn_r[k-1];
          cmx_r[k] <= cmx_r[k-1];
          cct_r[k] <= cct_r[k-1];
        end
      end
    end
  end

  // column over all active rows, newest row taken from the word itself
  always_comb begin
    c_mn = '1;
    c_mx = '0;
    c_ct = s2_r.gray;
    v    = '0;
    for (int s = 0; s < SLOTS; s++) begin
      v = (s2_r.wr && (s2_r.slot == SLOT_W'(s))) ? s2_r.gray : rdat[s];
      if (SLOT_W'(s) <= two_r) begin
        if (v < c_mn) c_mn = v;
        if (v > c_mx) c_mx = v;
      end
      if ((SLOT_W'(s) == s2_r.cslot) && (s2_r.cslot != s2_r.slot)) c_ct = rdat[s];
    end
  end

  always_comb begin
    w_mn = '1;
    w_mx = '0;
    w_ct = cct_r[0];
    for (int k = 0; k < SLOTS; k++) begin
      if (SLOT_W'(k) <= two_r) begin
        if (cmn_r[k] < w_mn) w_mn = cmn_r[k];
        if (cmx_r[k] > w_mx) w_mx = cmx_r[k];
      end
      if (SLOT_W'(k) == SLOT_W'(rad)) w_ct = cct_r[k];
    end
  end

  assign out_px.valid       = out_v_r;
  assign out_px.value       = out_val_r;
  assign out_px.is_interior = out_int_r;
  assign out_px.last        = out_last_r;

endmodule
